[rtl/hts_pkg.sv]
// Shared types and character constants for the HTML tag stripper.
package hts_pkg;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam int WORD_MAX = 7;

    typedef logic [7:0] word_t [WORD_MAX];

    localparam word_t WORD_SCRIPT  = '{8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74, 8'h00};
    localparam word_t WORD_STYLE   = '{8'h73, 8'h74, 8'h79, 8'h6C, 8'h65, 8'h00, 8'h00};
    localparam word_t WORD_CSCRIPT = '{8'h2F, 8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74};
    localparam word_t WORD_CSTYLE  = '{8'h2F, 8'h73, 8'h74, 8'h79, 8'h6C, 8'h65, 8'h00};

    localparam int LEN_SCRIPT  = 6;
    localparam int LEN_STYLE   = 5;
    localparam int LEN_CSCRIPT = 7;
    localparam int LEN_CSTYLE  = 6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // One queue entry: an optional leading space, then the byte (or an end-only item).
    typedef struct packed {
        logic       lead_space;
        logic [7:0] out_char;
        logic       has_char;
        logic       text_end;
    } entry_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= CH_UA && c <= CH_UZ) begin
            return c + CASE_OFS;
        end
        return c;
    endfunction

endpackage

[rtl/hts_front.sv]
// Front end: tag/skip/whitespace tracking, builds one queue entry per productive byte or document end.
module hts_front #(
    parameter int NAME_MAX = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic [7:0]          in_char,
    input  logic                doc_end,
    output logic                push,
    output hts_pkg::entry_t     entry
);

    localparam int LEN_W = $clog2(NAME_MAX + 2);

    logic             inside_tag_reg,    inside_tag_next;
    logic             skipping_reg,      skipping_next;
    logic [LEN_W-1:0] name_len_reg,      name_len_next;
    logic             name_fin_reg,      name_fin_next;
    logic             space_pend_reg,    space_pend_next;
    logic             started_reg,       started_next;
    logic [7:0]       name_reg [NAME_MAX];
    logic             name_wr;

    logic m_script, m_style, m_cscript, m_cstyle;

    function automatic logic name_is(input hts_pkg::word_t w, input int len,
                                     input logic [LEN_W-1:0] nlen,
                                     input logic [7:0] nb [NAME_MAX]);
        logic ok;
        ok = (nlen == LEN_W'(len));
        for (int i = 0; i < hts_pkg::WORD_MAX; i++) begin
            if (i < len && nb[i] != w[i]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    always_comb begin
        m_script  = name_is(hts_pkg::WORD_SCRIPT,  hts_pkg::LEN_SCRIPT,  name_len_reg, name_reg);
        m_style   = name_is(hts_pkg::WORD_STYLE,   hts_pkg::LEN_STYLE,   name_len_reg, name_reg);
        m_cscript = name_is(hts_pkg::WORD_CSCRIPT, hts_pkg::LEN_CSCRIPT, name_len_reg, name_reg);
        m_cstyle  = name_is(hts_pkg::WORD_CSTYLE,  hts_pkg::LEN_CSTYLE,  name_len_reg, name_reg);
    end

    always_comb begin
        inside_tag_next = inside_tag_reg;
        skipping_next   = skipping_reg;
        name_len_next   = name_len_reg;
        name_fin_next   = name_fin_reg;
        space_pend_next = space_pend_reg;
        started_next    = started_reg;
        name_wr         = 1'b0;
        push            = 1'b0;
        entry           = '0;
        if (in_fire) begin
            if (in_char == hts_pkg::CH_LT) begin
                inside_tag_next = 1'b1;
                name_len_next   = '0;
                name_fin_next   = 1'b0;
            end else if (inside_tag_reg) begin
                if (in_char == hts_pkg::CH_GT) begin
                    inside_tag_next = 1'b0;
                    if (!skipping_reg) begin
                        if (m_script || m_style) begin
                            skipping_next = 1'b1;
                        end
                    end else begin
                        if (m_cscript || m_cstyle) begin
                            skipping_next = 1'b0;
                        end
                    end
                    name_len_next = '0;
                    name_fin_next = 1'b0;
                end else if (hts_pkg::is_blank(in_char)) begin
                    name_fin_next = 1'b1;
                end else if (!name_fin_reg) begin
                    if (name_len_reg < LEN_W'(NAME_MAX)) begin
                        name_wr       = 1'b1;
                        name_len_next = name_len_reg + LEN_W'(1);
                    end else begin
                        name_len_next = LEN_W'(NAME_MAX + 1);
                    end
                end
            end else if (skipping_reg) begin
                // script/style body dropped
            end else if (hts_pkg::is_blank(in_char)) begin
                if (started_reg) begin
                    space_pend_next = 1'b1;
                end
            end else begin
                push             = 1'b1;
                entry.lead_space = space_pend_reg;
                entry.out_char   = in_char;
                entry.has_char   = 1'b1;
                space_pend_next  = 1'b0;
                started_next     = 1'b1;
            end
            if (doc_end) begin
                push            = 1'b1;
                entry.text_end  = 1'b1;
                inside_tag_next = 1'b0;
                skipping_next   = 1'b0;
                name_len_next   = '0;
                name_fin_next   = 1'b0;
                space_pend_next = 1'b0;
                started_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_tag_reg <= 1'b0;
            skipping_reg   <= 1'b0;
            name_len_reg   <= '0;
            name_fin_reg   <= 1'b0;
            space_pend_reg <= 1'b0;
            started_reg    <= 1'b0;
        end else begin
            inside_tag_reg <= inside_tag_next;
            skipping_reg   <= skipping_next;
            name_len_reg   <= name_len_next;
            name_fin_reg   <= name_fin_next;
            space_pend_reg <= space_pend_next;
            started_reg    <= started_next;
        end
    end

    // name bytes stored case-folded
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NAME_MAX; i++) begin
            if (name_wr && name_len_reg == LEN_W'(i)) begin
                name_reg[i] <= hts_pkg::fold_case(in_char);
            end
        end
    end

endmodule

[rtl/hts_queue.sv]
// Small FIFO of entries between front and back.
module hts_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  hts_pkg::entry_t push_data,
    input  logic            pop,
    output hts_pkg::entry_t head,
    output logic            not_empty,
    output logic            not_full
);

    localparam int CNT_W = hts_pkg::QUEUE_AW + 1;

    hts_pkg::entry_t                mem_reg [hts_pkg::QUEUE_DEPTH];
    logic [hts_pkg::QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [hts_pkg::QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]               count_reg,  count_next;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != CNT_W'(hts_pkg::QUEUE_DEPTH));
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + hts_pkg::QUEUE_AW'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + hts_pkg::QUEUE_AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/hts_back.sv]
// Back end: expands each entry into one or two output transfers.
module hts_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  hts_pkg::entry_t head,
    input  logic            head_valid,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tuser,
    output logic            m_tlast
);

    logic phase_reg, phase_next;
    logic space_turn;
    logic fire;

    assign space_turn = head.lead_space && !phase_reg;
    assign m_tvalid   = head_valid;
    assign fire       = head_valid && m_tready;
    assign pop        = fire && !space_turn;

    always_comb begin
        if (space_turn) begin
            m_tdata = hts_pkg::CH_SPACE;
            m_tuser = 1'b1;
            m_tlast = 1'b0;
        end else begin
            m_tdata = head.out_char;
            m_tuser = head.has_char;
            m_tlast = head.text_end;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        if (fire) begin
            phase_next = space_turn;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
        end
    end

endmodule

[rtl/html_tag_stripper.sv]
// Top level of the HTML tag stripper: front end, entry queue, back end.
//
//  channel | ports        | tdata           | tuser    | tlast
//  input   | s_t*         | in_char [7:0]   | -        | doc_end
//  result  | m_t*         | out_char [7:0]  | has_char | text_end
//
// One input byte per cycle while the queue is not full; the front end updates its
// state and writes an entry into a four-deep queue in the cycle of the transfer.
// A byte with a pending space yields two result transfers, so the output
// port sets the rate then.
// s_tready drops only when the queue is full. Reset (aresetn low, sync)
// clears tag, skip, space and queue state; no clearing pass.
module html_tag_stripper #(
    parameter int NAME_MAX = 7
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tuser,   // [0] has_char
    output logic       m_tlast
);

    logic            in_fire;
    logic            push;
    logic            pop;
    logic            not_empty;
    logic            not_full;
    hts_pkg::entry_t entry;
    hts_pkg::entry_t head;

    assign s_tready = not_full;
    assign in_fire  = s_tvalid && not_full;

    hts_front #(
        .NAME_MAX (NAME_MAX)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_char (s_tdata),
        .doc_end (s_tlast),
        .push    (push),
        .entry   (entry)
    );

    hts_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (entry),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .not_full  (not_full)
    );

    hts_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (not_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
